>>> sv/cafb_pkg.sv
`timescale 1ns / 1ps

package cafb_pkg;

  // Bank size and derived widths
  localparam int FILTER_SLOTS = 16;
  localparam int SLOT_W       = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
  localparam int MAP_W        = 16;
  localparam int WORD_W       = 32;
  localparam int IDENT_W      = 29;
  localparam int STD_W        = 11;

  // Item modes; code 3 means nothing
  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_MATCH  = 2'd2
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOT_USED = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FLUSH,
    S_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // latch the input beat, clear the match map
    logic exec;     // run add / remove / result setup
    logic scan_rd;  // read one slot of the table and advance
  } cafb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_match;
    logic scan_last;
  } cafb_stat_t;

endpackage

>>> sv/cafb_ctrl.sv
`timescale 1ns / 1ps

module cafb_ctrl import cafb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  cafb_stat_t stat,
  output cafb_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = stat.is_match ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        if (stat.scan_last) state_next = S_FLUSH;
      end
      S_FLUSH: state_next = S_RESP;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_EXEC:  cmd.exec    = 1'b1;
      S_SCAN:  cmd.scan_rd = 1'b1;
      S_FLUSH: ;
      S_RESP:  done        = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> sv/cafb_dp.sv
`timescale 1ns / 1ps

module cafb_dp import cafb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cafb_cmd_t            cmd,
  input  logic [1:0]           mode,
  input  logic [IDENT_W-1:0]   can_ident,
  input  logic                 extended,
  input  logic [WORD_W-1:0]    filter_mask,
  input  logic [3:0]           slot_index,
  output cafb_stat_t           stat,
  output logic [1:0]           status,
  output logic [3:0]           slot,
  output logic [MAP_W-1:0]     match_map
);

  localparam logic [WORD_W-1:0] EXT_FLAG = {1'b1, {(WORD_W-1){1'b0}}};

  // Latched input beat
  logic [1:0]          op;
  logic [IDENT_W-1:0]  ident;
  logic                ext;
  logic [WORD_W-1:0]   mask;
  logic [3:0]          idx;

  // Filter table
  logic [FILTER_SLOTS-1:0] used;
  logic [WORD_W-1:0]       tbl_ident [FILTER_SLOTS];
  logic [WORD_W-1:0]       tbl_mask  [FILTER_SLOTS];

  // Scan pipeline
  logic [SLOT_W-1:0] cnt;
  logic [SLOT_W-1:0] rd_idx;
  logic              rd_vld;
  logic [WORD_W-1:0] rd_ident;
  logic [WORD_W-1:0] rd_mask;

  logic              full;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] rm_idx;
  logic              rm_hit;
  logic              add_go;
  logic              rm_go;
  logic [WORD_W-1:0] new_ident;
  logic [WORD_W-1:0] new_mask;
  logic [WORD_W-1:0] cmp;
  logic              hit;

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= mode;
      ident <= can_ident;
      ext   <= extended;
      mask  <= filter_mask;
      idx   <= slot_index;
    end
  end

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = FILTER_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) free_idx = SLOT_W'(i);
    end
  end

  assign full   = &used;
  assign rm_idx = SLOT_W'(idx);
  assign rm_hit = (32'(idx) < FILTER_SLOTS) && used[rm_idx];
  assign add_go = cmd.exec && (op == MODE_ADD) && !full;
  assign rm_go  = cmd.exec && (op == MODE_REMOVE) && rm_hit;

  // Entry to store on add
  always_comb begin
    if (ext) begin
      new_ident = {{(WORD_W-IDENT_W){1'b0}}, ident} | EXT_FLAG;
      new_mask  = mask | EXT_FLAG;
    end else begin
      new_ident = {{(WORD_W-STD_W){1'b0}}, ident[STD_W-1:0]};
      new_mask  = mask;
    end
  end

  // Slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (add_go) begin
      used[free_idx] <= 1'b1;
    end else if (rm_go) begin
      used[rm_idx] <= 1'b0;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (add_go) begin
      tbl_ident[free_idx] <= new_ident;
      tbl_mask[free_idx]  <= new_mask;
    end
    if (cmd.scan_rd) begin
      rd_ident <= tbl_ident[cnt];
      rd_mask  <= tbl_mask[cnt];
    end
  end

  // Scan counter and read tag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.scan_rd) begin
      cnt <= cnt + SLOT_W'(1);
    end
    if (cmd.scan_rd) rd_idx <= cnt;
  end

  // Compare stage
  assign cmp = {ext, {(WORD_W-IDENT_W-1){1'b0}}, ident};
  assign hit = used[rd_idx] && ((cmp & rd_mask) == (rd_ident & rd_mask));

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match_map <= '0;
    end else if (rd_vld && hit && (32'(rd_idx) < MAP_W)) begin
      match_map[4'(rd_idx)] <= 1'b1;
    end
    if (cmd.exec) begin
      status <= STAT_OK;
      slot   <= '0;
      case (op)
        MODE_ADD: begin
          if (full) status <= STAT_FULL;
          else      slot   <= 4'(free_idx);
        end
        MODE_REMOVE: begin
          if (!rm_hit) status <= STAT_NOT_USED;
        end
        default: ;
      endcase
    end
  end

  assign stat.is_match  = (op == MODE_MATCH);
  assign stat.scan_last = (cnt == SLOT_W'(FILTER_SLOTS - 1));

endmodule

>>> sv/can_acceptance_filter_bank_top.sv
`timescale 1ns / 1ps
// Add, remove and unused mode go from start through the exec state to done;
// a frame match then scans every table slot before a flush state and done,
// reading one table slot per cycle through one read port.
// Busy stays high until done has passed, so a new item is taken only after the last is done.
// Reset (rst, synchronous): controller idle, all slots free; results are not stalled.

module can_acceptance_filter_bank_top import cafb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode,
  input  logic [IDENT_W-1:0]  can_ident,
  input  logic                extended,
  input  logic [WORD_W-1:0]   filter_mask,
  input  logic [3:0]          slot_index,
  output logic                done,
  output logic [1:0]          status,
  output logic [3:0]          slot,
  output logic [MAP_W-1:0]    match_map
);

  cafb_cmd_t  cmd;
  cafb_stat_t stat;

  cafb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  cafb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .can_ident   (can_ident),
    .extended    (extended),
    .filter_mask (filter_mask),
    .slot_index  (slot_index),
    .stat        (stat),
    .status      (status),
    .slot        (slot),
    .match_map   (match_map)
  );

  // Accepted beat makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  // A result is only given while an item is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without item in flight");

  // Strobe lasts one cycle, then the block is free again
  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("done not followed by idle");

  // Only a frame item may report matches, and it always reports ok
  a_map_status: assert property (@(posedge clk) disable iff (rst)
    (done && (match_map != '0)) |-> ((status == STAT_OK) && (slot == '0)))
    else $error("match map with non-frame result");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cafb_pkg::*;

  // Mode code 3 does nothing in the block
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int RANDOM_BEATS = 1850;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = FILTER_SLOTS + 8;
  localparam int POOL_DEPTH   = 32;

  typedef struct {
    logic [1:0]         op;
    logic [IDENT_W-1:0] ident;
    logic               ext;
    logic [WORD_W-1:0]  mask;
    logic [3:0]         idx;
  } filter_beat_t;

  typedef struct {
    logic [1:0]       status;
    logic [3:0]       slot;
    logic [MAP_W-1:0] map;
  } filter_resp_t;

  logic               clk;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic [1:0]         mode        = '0;
  logic [IDENT_W-1:0] can_ident   = '0;
  logic               extended    = 1'b0;
  logic [WORD_W-1:0]  filter_mask = '0;
  logic [3:0]         slot_index  = '0;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic [3:0]         slot;
  logic [MAP_W-1:0]   match_map;

  // Shadow copy of the filter table
  logic              bank_used  [FILTER_SLOTS];
  logic [WORD_W-1:0] bank_ident [FILTER_SLOTS];
  logic [WORD_W-1:0] bank_mask  [FILTER_SLOTS];

  filter_resp_t expected_resp [$];
  filter_beat_t added_filters [$];
  filter_resp_t want;
  int           err_count  = 0;
  int           idle_count = 0;
  bit           burst      = 1'b0;
  bit           fill_bias  = 1'b1;

  can_acceptance_filter_bank_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .can_ident   (can_ident),
    .extended    (extended),
    .filter_mask (filter_mask),
    .slot_index  (slot_index),
    .done        (done),
    .status      (status),
    .slot        (slot),
    .match_map   (match_map)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic filter_beat_t beat(logic [1:0] op, logic [IDENT_W-1:0] ident,
                                        logic ext, logic [WORD_W-1:0] mask,
                                        logic [3:0] idx);
    filter_beat_t b;
    b.op    = op;
    b.ident = ident;
    b.ext   = ext;
    b.mask  = mask;
    b.idx   = idx;
    return b;
  endfunction

  // Apply one beat to the shadow table and return the response it gives
  function automatic filter_resp_t apply_filter_op(filter_beat_t b);
    filter_resp_t      r;
    logic [WORD_W-1:0] cmp;
    int                free_slot;
    r.status = STAT_OK;
    r.slot   = '0;
    r.map    = '0;
    case (b.op)
      MODE_ADD: begin
        free_slot = -1;
        for (int i = 0; i < FILTER_SLOTS; i++)
          if (!bank_used[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          r.status = STAT_FULL;
        end else begin
          if (b.ext) begin
            bank_ident[free_slot] = {1'b1, 2'b00, b.ident};
            bank_mask[free_slot]  = b.mask | 32'h8000_0000;
          end else begin
            bank_ident[free_slot] = {{(WORD_W-STD_W){1'b0}}, b.ident[STD_W-1:0]};
            bank_mask[free_slot]  = b.mask;
          end
          bank_used[free_slot] = 1'b1;
          r.slot = free_slot[3:0];
        end
      end
      MODE_REMOVE: begin
        if (int'(b.idx) >= FILTER_SLOTS || !bank_used[b.idx]) begin
          r.status = STAT_NOT_USED;
        end else begin
          bank_used[b.idx]  = 1'b0;
          bank_ident[b.idx] = '0;
          bank_mask[b.idx]  = '0;
        end
      end
      MODE_MATCH: begin
        // Standard frames keep all 29 bits in the compare
        cmp = {b.ext, 2'b00, b.ident};
        for (int i = 0; i < FILTER_SLOTS && i < MAP_W; i++)
          if (bank_used[i] && (cmp & bank_mask[i]) == (bank_ident[i] & bank_mask[i]))
            r.map[i] = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand_mask();
    logic [WORD_W-1:0] m;
    case ($urandom_range(0, 5))
      0:       m = '1;
      1:       m = 32'h0000_07FF;
      2:       m = 32'h1FFF_FFFF;
      3:       m = '0;
      4:       m = $urandom & 32'h0000_07F0;
      default: m = $urandom;
    endcase
    if ($urandom_range(0, 3) == 0) m[31] = ~m[31];
    return m;
  endfunction

  // Random beat: mostly adds, removes of live slots and frames near stored ids
  function automatic filter_beat_t rand_beat();
    filter_beat_t b;
    filter_beat_t p;
    int           pick;
    int           live [$];
    b = beat(MODE_NOP, IDENT_W'($urandom), 1'($urandom_range(0, 1)), $urandom,
             4'($urandom_range(0, 15)));
    pick = $urandom_range(0, 99);
    if (pick < (fill_bias ? 35 : 15)) begin
      b.op   = MODE_ADD;
      b.mask = rand_mask();
      if ($urandom_range(0, 2) == 0) b.ident = IDENT_W'($urandom & 32'h7FF);
    end else if (pick < 50) begin
      b.op = MODE_REMOVE;
      for (int i = 0; i < FILTER_SLOTS; i++)
        if (bank_used[i]) live.push_back(i);
      if (live.size() > 0 && $urandom_range(0, 9) < 7)
        b.idx = 4'(live[$urandom_range(0, live.size() - 1)]);
    end else if (pick < 95) begin
      b.op = MODE_MATCH;
      if (added_filters.size() > 0 && $urandom_range(0, 9) < 7) begin
        p = added_filters[$urandom_range(0, added_filters.size() - 1)];
        b.ident = p.ident;
        b.ext   = p.ext;
        if (!p.ext && $urandom_range(0, 1) == 0)
          b.ident = {{(IDENT_W-STD_W){1'b0}}, b.ident[STD_W-1:0]};
        if ($urandom_range(0, 3) == 0) b.ident[5'($urandom_range(0, IDENT_W - 1))] ^= 1'b1;
        if ($urandom_range(0, 6) == 0) b.ext = ~b.ext;
      end
    end
    return b;
  endfunction

  // Drive one beat and hold it until the block takes it
  task automatic send_beat(filter_beat_t b);
    start       <= 1'b1;
    mode        <= b.op;
    can_ident   <= b.ident;
    extended    <= b.ext;
    filter_mask <= b.mask;
    slot_index  <= b.idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_resp.push_back(apply_filter_op(b));
    if (b.op == MODE_ADD) begin
      added_filters.push_back(b);
      if (added_filters.size() > POOL_DEPTH) void'(added_filters.pop_front());
    end
  endtask

  // Random pause between beats; none during a burst
  task automatic idle_gap();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (burst)        n = 0;
    else if (r < 70)  n = $urandom_range(0, 2);
    else if (r < 95)  n = $urandom_range(3, 8);
    else              n = $urandom_range(20, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic test_empty_bank();
    send_beat(beat(MODE_MATCH, '1, 1'b1, '1, '0));
    idle_gap();
    send_beat(beat(MODE_REMOVE, '0, 1'b0, '0, 4'd0));
    idle_gap();
    send_beat(beat(MODE_REMOVE, '1, 1'b1, '1, 4'd15));
    idle_gap();
    send_beat(beat(MODE_NOP, '1, 1'b1, '1, 4'd15));
    idle_gap();
  endtask

  // Fill every slot with edge-case filters, then overflow the table
  task automatic test_fill_and_full();
    send_beat(beat(MODE_ADD, '1, 1'b1, '1, '0));
    send_beat(beat(MODE_ADD, '1, 1'b0, 32'h0000_07FF, '0));
    idle_gap();
    send_beat(beat(MODE_ADD, '0, 1'b1, '0, '0));
    send_beat(beat(MODE_ADD, '0, 1'b0, '0, '0));
    idle_gap();
    for (int i = 4; i < FILTER_SLOTS; i++) begin
      send_beat(beat(MODE_ADD, IDENT_W'($urandom), i[0], rand_mask(), '1));
      idle_gap();
    end
    send_beat(beat(MODE_ADD, '1, 1'b1, '1, '0));
    idle_gap();
  endtask

  task automatic test_match_rules();
    send_beat(beat(MODE_MATCH, 29'h7FF, 1'b0, '0, '0));
    idle_gap();
    // upper bits of a standard frame still take part in the compare
    send_beat(beat(MODE_MATCH, 29'h1FFF_FFFF, 1'b0, '0, '0));
    send_beat(beat(MODE_REMOVE, '0, 1'b0, '0, 4'd1));
    idle_gap();
    // freed slot is the lowest free one again
    send_beat(beat(MODE_ADD, 29'h155, 1'b0, 32'hFFFF_FFFF, '0));
    idle_gap();
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 60 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n % 120 == 0) fill_bias = ~fill_bias;
      send_beat(rand_beat());
      idle_gap();
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, got_val);
      err_count++;
    end
  endtask

  // Response checker: every done beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_resp.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0h slot %0h map %0h",
                 $time, status, slot, match_map);
        err_count++;
      end else begin
        want = expected_resp.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("slot", 32'(want.slot), 32'(slot));
        check_field("match_map", 32'(want.map), 32'(match_map));
      end
    end
  end

  // Watchdog on cycles with no beat moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < FILTER_SLOTS; i++) begin
      bank_used[i]  = 1'b0;
      bank_ident[i] = '0;
      bank_mask[i]  = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_bank();
    test_fill_and_full();
    test_match_rules();
    test_random_traffic();
    start <= 1'b0;
    while (expected_resp.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
